@@ hw/rtl/pit_pkg.sv @@
// package for the points in triangle counter
// sizes, arithmetic widths, controller states and command/status structs
// no dependencies
package pit_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 16;

    localparam int COORD_IN_W = 16;
    localparam int IDX_W      = 10;
    localparam int CNT_OUT_W  = 11;

    localparam int PTR_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    localparam int E_W  = COORD_BITS + 1;
    localparam int S_W  = COORD_BITS + 2;
    localparam int P_W  = 2 * COORD_BITS;
    localparam int EC_W = 2 * COORD_BITS + 1;
    localparam int Q_W  = 2 * COORD_BITS + 1;
    localparam int MP_W = 2 * COORD_BITS + 3;
    localparam int M_W  = 2 * COORD_BITS + 3;
    localparam int MC_W = 2 * COORD_BITS + 5;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_CAP_C,
        ST_COEF1,
        ST_COEF2,
        ST_CENT1,
        ST_CENT2,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        SRC_A,
        SRC_B,
        SRC_C,
        SRC_SWEEP
    } t_rd_src;

    typedef struct packed {
        logic       load_we;
        logic       start;
        logic       rd_en;
        t_rd_src    rd_src;
        logic [2:0] cap_v;
        logic       coef1;
        logic       coef2;
        logic       cent1;
        logic       cent2;
        logic       sweep_rd;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic bad;
        logic sweep_last;
        logic pipe_busy;
        logic out_free;
    } t_status;

endpackage

@@ hw/rtl/pit_if.sv @@
// valid/ready channel interfaces for query/load items and results
// depends on pit_pkg
interface pit_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  op;
    logic signed [pit_pkg::COORD_IN_W-1:0] coord_x;
    logic signed [pit_pkg::COORD_IN_W-1:0] coord_y;
    logic        [pit_pkg::IDX_W-1:0]      corner_a;
    logic        [pit_pkg::IDX_W-1:0]      corner_b;
    logic        [pit_pkg::IDX_W-1:0]      corner_c;

    modport source (
        output valid, op, coord_x, coord_y, corner_a, corner_b, corner_c,
        input  ready
    );
    modport sink (
        input  valid, op, coord_x, coord_y, corner_a, corner_b, corner_c,
        output ready
    );
endinterface

interface pit_out_if;
    logic                             valid;
    logic                             ready;
    logic [pit_pkg::CNT_OUT_W-1:0]    inside_count;
    logic                             bad_index;

    modport source (
        output valid, inside_count, bad_index,
        input  ready
    );
    modport sink (
        input  valid, inside_count, bad_index,
        output ready
    );
endinterface

@@ hw/rtl/points_in_triangle_counter.sv @@
// points in triangle counter: one load transfer per cycle while idle
// query with n stored points: corner reads, edge coefficients, centroid side,
// then the sweep reading one stored point per cycle from the store ram, then drain
// bad corner index: the query skips the sweep and goes straight to the result register
// next item taken once the query leaves the sweep and its result is registered
// synchronous active-low reset clears point count, control state and valids
module points_in_triangle_counter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pit_in_if.sink         i_in,
    pit_out_if.source      o_out
);

    pit_pkg::t_cmd    cmd;
    pit_pkg::t_status status;

    pit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pit_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_coord_x      (i_in.coord_x),
        .i_coord_y      (i_in.coord_y),
        .i_corner_a     (i_in.corner_a),
        .i_corner_b     (i_in.corner_b),
        .i_corner_c     (i_in.corner_c),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_inside_count (o_out.inside_count),
        .o_bad_index    (o_out.bad_index)
    );

endmodule

@@ hw/rtl/pit_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
module pit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/pit_ctrl.sv @@
// controller state machine: load handling, query sequencing, result hand-off
// depends on pit_pkg
module pit_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_op,
    output logic             o_in_ready,
    input  pit_pkg::t_status i_status,
    output pit_pkg::t_cmd    o_cmd
);

    pit_pkg::t_state r_state;
    pit_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pit_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pit_pkg::ST_IDLE: begin
                if (i_in_valid && (i_in_op == pit_pkg::OP_QUERY)) begin
                    n_state = i_status.bad ? pit_pkg::ST_FINISH : pit_pkg::ST_RD_A;
                end
            end
            pit_pkg::ST_RD_A:  n_state = pit_pkg::ST_RD_B;
            pit_pkg::ST_RD_B:  n_state = pit_pkg::ST_RD_C;
            pit_pkg::ST_RD_C:  n_state = pit_pkg::ST_CAP_C;
            pit_pkg::ST_CAP_C: n_state = pit_pkg::ST_COEF1;
            pit_pkg::ST_COEF1: n_state = pit_pkg::ST_COEF2;
            pit_pkg::ST_COEF2: n_state = pit_pkg::ST_CENT1;
            pit_pkg::ST_CENT1: n_state = pit_pkg::ST_CENT2;
            pit_pkg::ST_CENT2: n_state = pit_pkg::ST_SWEEP;
            pit_pkg::ST_SWEEP: begin
                if (i_status.sweep_last) begin
                    n_state = pit_pkg::ST_DRAIN;
                end
            end
            pit_pkg::ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = pit_pkg::ST_FINISH;
                end
            end
            pit_pkg::ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = pit_pkg::ST_IDLE;
                end
            end
            default: n_state = pit_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            pit_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == pit_pkg::OP_LOAD) begin
                        o_cmd.load_we = !i_status.full;
                    end else begin
                        o_cmd.start = 1'b1;
                    end
                end
            end
            pit_pkg::ST_RD_A: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = pit_pkg::SRC_A;
            end
            pit_pkg::ST_RD_B: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = pit_pkg::SRC_B;
                o_cmd.cap_v  = 3'b001;
            end
            pit_pkg::ST_RD_C: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_src = pit_pkg::SRC_C;
                o_cmd.cap_v  = 3'b010;
            end
            pit_pkg::ST_CAP_C: o_cmd.cap_v = 3'b100;
            pit_pkg::ST_COEF1: o_cmd.coef1 = 1'b1;
            pit_pkg::ST_COEF2: o_cmd.coef2 = 1'b1;
            pit_pkg::ST_CENT1: o_cmd.cent1 = 1'b1;
            pit_pkg::ST_CENT2: o_cmd.cent2 = 1'b1;
            pit_pkg::ST_SWEEP: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_src   = pit_pkg::SRC_SWEEP;
                o_cmd.sweep_rd = 1'b1;
            end
            pit_pkg::ST_DRAIN: begin
                o_cmd = '0;
            end
            pit_pkg::ST_FINISH: o_cmd.out_load = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ hw/rtl/pit_datapath.sv @@
// datapath: point store, corner capture, edge coefficients, centroid side,
// per-point side test pipeline, counter and result register
// depends on pit_pkg and pit_ram
module pit_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pit_pkg::t_cmd                         i_cmd,
    output pit_pkg::t_status                      o_status,
    input  logic signed [pit_pkg::COORD_IN_W-1:0] i_coord_x,
    input  logic signed [pit_pkg::COORD_IN_W-1:0] i_coord_y,
    input  logic        [pit_pkg::IDX_W-1:0]      i_corner_a,
    input  logic        [pit_pkg::IDX_W-1:0]      i_corner_b,
    input  logic        [pit_pkg::IDX_W-1:0]      i_corner_c,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic        [pit_pkg::CNT_OUT_W-1:0]  o_inside_count,
    output logic                                  o_bad_index
);

    localparam int CB = pit_pkg::COORD_BITS;

    logic [pit_pkg::CNT_W-1:0] r_loaded;
    logic [pit_pkg::PTR_W-1:0] r_idx;
    logic [pit_pkg::IDX_W-1:0] r_ca;
    logic [pit_pkg::IDX_W-1:0] r_cb;
    logic [pit_pkg::IDX_W-1:0] r_cc;
    logic [pit_pkg::CNT_W-1:0] r_count;
    logic                      r_bad;

    logic [pit_pkg::PTR_W-1:0] raddr;
    logic [2*CB-1:0]           wdata;
    logic [2*CB-1:0]           rdata;
    pit_pkg::t_coord           px;
    pit_pkg::t_coord           py;
    logic                      bad_now;

    pit_pkg::t_coord                  r_vx [3];
    pit_pkg::t_coord                  r_vy [3];
    pit_pkg::t_coord                  vxn  [3];
    pit_pkg::t_coord                  vyn  [3];
    logic signed [pit_pkg::E_W-1:0]   r_ea [3];
    logic signed [pit_pkg::E_W-1:0]   r_eb [3];
    logic signed [pit_pkg::P_W-1:0]   r_pa [3];
    logic signed [pit_pkg::P_W-1:0]   r_pb [3];
    logic signed [pit_pkg::EC_W-1:0]  r_ec [3];
    logic signed [pit_pkg::S_W-1:0]   r_sx;
    logic signed [pit_pkg::S_W-1:0]   r_sy;
    logic signed [pit_pkg::M_W-1:0]   r_ma [3];
    logic signed [pit_pkg::M_W-1:0]   r_mb [3];
    logic                             r_want [3];
    logic signed [pit_pkg::Q_W-1:0]   r_qa [3];
    logic signed [pit_pkg::Q_W-1:0]   r_qb [3];
    logic signed [pit_pkg::MC_W-1:0]  csum [3];
    logic signed [pit_pkg::MP_W-1:0]  psum [3];
    logic                             side_ok [3];

    logic r_rv;
    logic r_v1;
    logic r_v2;
    logic r_hit;

    logic                           r_out_valid;
    logic [pit_pkg::CNT_OUT_W-1:0]  r_out_count;
    logic                           r_out_bad;

    // point store, x in the upper half
    assign wdata = {CB'(i_coord_x), CB'(i_coord_y)};

    always_comb begin
        case (i_cmd.rd_src)
            pit_pkg::SRC_A:     raddr = pit_pkg::PTR_W'(r_ca);
            pit_pkg::SRC_B:     raddr = pit_pkg::PTR_W'(r_cb);
            pit_pkg::SRC_C:     raddr = pit_pkg::PTR_W'(r_cc);
            pit_pkg::SRC_SWEEP: raddr = r_idx;
            default:            raddr = r_idx;
        endcase
    end

    pit_ram #(
        .WIDTH (2 * CB),
        .DEPTH (pit_pkg::MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_we),
        .i_waddr (pit_pkg::PTR_W'(r_loaded)),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign px = pit_pkg::t_coord'(rdata[2*CB-1:CB]);
    assign py = pit_pkg::t_coord'(rdata[CB-1:0]);

    assign bad_now = (32'(i_corner_a) >= 32'(r_loaded))
                  || (32'(i_corner_b) >= 32'(r_loaded))
                  || (32'(i_corner_c) >= 32'(r_loaded));

    assign o_status.full       = (r_loaded == pit_pkg::CNT_W'(pit_pkg::MAX_POINTS));
    assign o_status.bad        = bad_now;
    assign o_status.sweep_last = (pit_pkg::CNT_W'(r_idx)
                                  == (r_loaded - pit_pkg::CNT_W'(1)));
    assign o_status.pipe_busy  = r_rv || r_v1 || r_v2;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded    <= '0;
            r_rv        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_we) begin
                r_loaded <= r_loaded + pit_pkg::CNT_W'(1);
            end
            r_rv <= i_cmd.sweep_rd;
            r_v1 <= r_rv;
            r_v2 <= r_v1;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // query setup
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ca    <= i_corner_a;
            r_cb    <= i_corner_b;
            r_cc    <= i_corner_c;
            r_bad   <= bad_now;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.sweep_rd) begin
                r_idx <= r_idx + pit_pkg::PTR_W'(1);
            end
            if (r_v2 && r_hit) begin
                r_count <= r_count + pit_pkg::CNT_W'(1);
            end
        end
        if (i_cmd.out_load) begin
            r_out_count <= pit_pkg::CNT_OUT_W'(r_count);
            r_out_bad   <= r_bad;
        end
    end

    assign vxn[0] = r_vx[1];
    assign vxn[1] = r_vx[2];
    assign vxn[2] = r_vx[0];
    assign vyn[0] = r_vy[1];
    assign vyn[1] = r_vy[2];
    assign vyn[2] = r_vy[0];

    always_comb begin
        for (int q = 0; q < 3; q++) begin
            csum[q] = pit_pkg::MC_W'(r_ma[q]) + pit_pkg::MC_W'(r_mb[q])
                    + pit_pkg::MC_W'(r_ec[q]) + (pit_pkg::MC_W'(r_ec[q]) <<< 1);
            psum[q] = pit_pkg::MP_W'(r_qa[q]) + pit_pkg::MP_W'(r_qb[q])
                    + pit_pkg::MP_W'(r_ec[q]);
            if (r_want[q]) begin
                side_ok[q] = !psum[q][pit_pkg::MP_W-1] && (psum[q] != '0);
            end else begin
                side_ok[q] = psum[q][pit_pkg::MP_W-1];
            end
        end
    end

    // edge coefficients, centroid side and per-point pipeline
    always_ff @(posedge i_clk) begin
        for (int q = 0; q < 3; q++) begin
            if (i_cmd.cap_v[q]) begin
                r_vx[q] <= px;
                r_vy[q] <= py;
            end
            if (i_cmd.coef1) begin
                r_ea[q] <= pit_pkg::E_W'(r_vy[q]) - pit_pkg::E_W'(vyn[q]);
                r_eb[q] <= pit_pkg::E_W'(vxn[q]) - pit_pkg::E_W'(r_vx[q]);
                r_pa[q] <= pit_pkg::P_W'(r_vx[q]) * pit_pkg::P_W'(vyn[q]);
                r_pb[q] <= pit_pkg::P_W'(vxn[q]) * pit_pkg::P_W'(r_vy[q]);
            end
            if (i_cmd.coef2) begin
                r_ec[q] <= pit_pkg::EC_W'(r_pa[q]) - pit_pkg::EC_W'(r_pb[q]);
            end
            if (i_cmd.cent1) begin
                r_ma[q] <= pit_pkg::M_W'(r_ea[q]) * pit_pkg::M_W'(r_sx);
                r_mb[q] <= pit_pkg::M_W'(r_eb[q]) * pit_pkg::M_W'(r_sy);
            end
            if (i_cmd.cent2) begin
                r_want[q] <= !csum[q][pit_pkg::MC_W-1] && (csum[q] != '0);
            end
            if (r_rv) begin
                r_qa[q] <= pit_pkg::Q_W'(r_ea[q]) * pit_pkg::Q_W'(px);
                r_qb[q] <= pit_pkg::Q_W'(r_eb[q]) * pit_pkg::Q_W'(py);
            end
        end
        if (i_cmd.coef1) begin
            r_sx <= pit_pkg::S_W'(r_vx[0]) + pit_pkg::S_W'(r_vx[1])
                  + pit_pkg::S_W'(r_vx[2]);
            r_sy <= pit_pkg::S_W'(r_vy[0]) + pit_pkg::S_W'(r_vy[1])
                  + pit_pkg::S_W'(r_vy[2]);
        end
        if (r_v1) begin
            r_hit <= side_ok[0] && side_ok[1] && side_ok[2];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_inside_count = r_out_count;
    assign o_bad_index    = r_out_bad;

    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= pit_pkg::CNT_W'(pit_pkg::MAX_POINTS))
        else $error("point count above capacity");

    a_load_on_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before transfer");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> !(r_out_bad && (r_out_count != '0)))
        else $error("bad index result with nonzero count");

    a_no_load_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rv || r_v1 || r_v2) |-> !i_cmd.load_we)
        else $error("store written during a sweep");

endmodule
